// ----- hw/rtl/spnc_pkg.sv -----
// ----------------------------------------------------------------------------
// spnc_pkg - shared types and constants for the shortest path core
// Action codes, sequencer states, edge record layout and the control bundle
// that drives the vertex state unit.
// ----------------------------------------------------------------------------
package spnc_pkg;

  localparam int DEF_MAX_VERTICES = 16;
  localparam int DEF_MAX_EDGES    = 64;

  localparam int DIST_W   = 25;  // stored distance, two's complement
  localparam int WEIGHT_W = 16;  // edge weight, two's complement
  localparam int VFIELD_W = 4;   // vertex fields on the ports
  localparam int VC_W     = 5;   // vertex_count register width

  localparam logic [VC_W-1:0] VC_RESET = 5'd16;

  localparam logic KIND_DIST  = 1'b0;
  localparam logic KIND_CYCLE = 1'b1;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_RUN   = 2'd2
  } act_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_EDGE_FETCH,
    ST_EDGE_EVAL,
    ST_WALK,
    ST_DIST_RD,
    ST_DIST_EMIT,
    ST_CYC_RD,
    ST_CYC_EMIT
  } state_t;

  typedef struct packed {
    logic [VFIELD_W-1:0]        src;
    logic [VFIELD_W-1:0]        dst;
    logic signed [WEIGHT_W-1:0] weight;
  } edge_t;

  // Control bundle from the sequencer to the vertex state unit.
  typedef struct packed {
    logic clear;    // drop all reached marks and predecessors
    logic seed;     // mark addr_a reached with distance 0
    logic rd;       // read both distance ports, capture edge operands
    logic edge_ok;  // both endpoints of the captured edge are in use
    logic eval;     // relax check on the captured edge, commit if it improves
  } vs_ctrl_t;

endpackage

// ----- hw/rtl/spnc_vertex_unit.sv -----
// ----------------------------------------------------------------------------
// spnc_vertex_unit - per-vertex state and the shared relax unit
// Holds distances (two-read memory), reached marks and predecessors, and does
// the add / compare / saturate / write-back for one edge at a time.
// ----------------------------------------------------------------------------
module spnc_vertex_unit #(
  parameter int MAX_VERTICES = spnc_pkg::DEF_MAX_VERTICES,
  localparam int VW = $clog2(MAX_VERTICES)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  spnc_pkg::vs_ctrl_t                 ctrl,
  input  logic [VW-1:0]                      addr_a,
  input  logic [VW-1:0]                      addr_b,
  input  logic signed [spnc_pkg::WEIGHT_W-1:0] weight,
  input  logic [VW-1:0]                      pred_idx,
  output logic                               relax,
  output logic signed [spnc_pkg::DIST_W-1:0] rd_dist,
  output logic                               rd_reached,
  output logic                               pred_valid_at,
  output logic [VW-1:0]                      pred_at
);

  localparam int DW = spnc_pkg::DIST_W;
  localparam int WW = spnc_pkg::WEIGHT_W;
  localparam logic signed [DW-1:0] DIST_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] DIST_MIN = {1'b1, {(DW-1){1'b0}}};

  logic signed [DW-1:0] dist_mem [MAX_VERTICES];
  logic signed [DW-1:0] da;
  logic signed [DW-1:0] db;
  logic                 reached_a;
  logic                 reached_b;
  logic [VW-1:0]        from_q;
  logic [VW-1:0]        to_q;
  logic signed [WW-1:0] weight_q;
  logic                 edge_ok_q;

  logic [MAX_VERTICES-1:0] reached;
  logic [MAX_VERTICES-1:0] reached_next;
  logic [MAX_VERTICES-1:0] pred_ok;
  logic [MAX_VERTICES-1:0] pred_ok_next;
  logic [VW-1:0]           pred_vtx [MAX_VERTICES];

  logic signed [DW:0]   cand;
  logic signed [DW:0]   db_ext;
  logic                 less;
  logic                 commit;
  logic signed [DW-1:0] clamped;
  logic                 we;
  logic [VW-1:0]        wa;
  logic signed [DW-1:0] wd;

  // one adder, one compare, saturate to the stored range
  assign cand    = $signed({da[DW-1], da}) + $signed({{(DW+1-WW){weight_q[WW-1]}}, weight_q});
  assign db_ext  = $signed({db[DW-1], db});
  assign less    = cand < db_ext;
  assign relax   = edge_ok_q & reached_a & (~reached_b | less);
  assign commit  = ctrl.eval & relax;
  assign clamped = (cand[DW] != cand[DW-1]) ? (cand[DW] ? DIST_MIN : DIST_MAX)
                                            : cand[DW-1:0];

  assign we = ctrl.seed | commit;
  assign wa = ctrl.seed ? addr_a : to_q;
  assign wd = ctrl.seed ? '0 : clamped;

  always_ff @(posedge clk) begin
    if (we) begin
      dist_mem[wa] <= wd;
    end
    if (ctrl.rd) begin
      da <= dist_mem[addr_a];
      db <= dist_mem[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd) begin
      reached_a <= reached[addr_a];
      reached_b <= reached[addr_b];
      from_q    <= addr_a;
      to_q      <= addr_b;
      weight_q  <= weight;
      edge_ok_q <= ctrl.edge_ok;
    end
    if (commit) begin
      pred_vtx[to_q] <= from_q;
    end
  end

  // clear first, then the seed or a committed relax sets its bit
  always_comb begin
    reached_next = ctrl.clear ? '0 : reached;
    pred_ok_next = ctrl.clear ? '0 : pred_ok;
    if (ctrl.seed) begin
      reached_next[addr_a] = 1'b1;
    end
    if (commit) begin
      reached_next[to_q] = 1'b1;
      pred_ok_next[to_q] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reached <= '0;
      pred_ok <= '0;
    end else begin
      reached <= reached_next;
      pred_ok <= pred_ok_next;
    end
  end

  assign rd_dist       = da;
  assign rd_reached    = reached_a;
  assign pred_valid_at = pred_ok[pred_idx];
  assign pred_at       = pred_vtx[pred_idx];

endmodule

// ----- hw/rtl/shortest_path_negative_cycle_core.sv -----
// ----------------------------------------------------------------------------
// shortest_path_negative_cycle_core - single-source shortest paths engine
// Edge list store, relax sequencer and result emitter with negative cycle walk.
// ----------------------------------------------------------------------------
// Beats on the input channel are actions: clear the edge table, add one edge
// (dropped once MAX_EDGES are stored), or run a search from start_vertex.
// Clear and add produce no result. A run holds
// in_stall high until its last result has been loaded into the output
// register; it relaxes every stored edge, in load order, once per pass for n
// passes (n = vertex_count clamped to 1..MAX_VERTICES), then makes one more
// pass that stops at the first edge that still improves. Each edge goes
// through the single relax unit as a distance memory read, then an add /
// compare / write back, with the next edge read from the edge memory
// in the shadow of the current one. Each result is a distance memory read,
// then an output load, which waits while the output stalls. Results: one
// distance beat per vertex in index order (kind 0); if a negative cycle was
// found and the walk back through predecessors lands on a valid vertex, the
// cycle vertices follow (kind 1, at most n). last marks the final beat of
// the run and negative_cycle is the same on every beat of it. Unreached
// vertices report distance 0. vertex_count is written through the cfg
// channel; the user must write it only while the core is idle, which the
// core does not enforce. cfg_ready is always high.
// ----------------------------------------------------------------------------
module shortest_path_negative_cycle_core #(
  parameter int MAX_VERTICES = spnc_pkg::DEF_MAX_VERTICES,
  parameter int MAX_EDGES    = spnc_pkg::DEF_MAX_EDGES
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // action channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           action,
  input  logic [spnc_pkg::VFIELD_W-1:0]        edge_from,
  input  logic [spnc_pkg::VFIELD_W-1:0]        edge_to,
  input  logic signed [spnc_pkg::WEIGHT_W-1:0] edge_weight,
  input  logic [spnc_pkg::VFIELD_W-1:0]        start_vertex,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 kind,
  output logic [spnc_pkg::VFIELD_W-1:0]        vertex,
  output logic signed [spnc_pkg::DIST_W-1:0]   distance,
  output logic                                 reachable,
  output logic                                 negative_cycle,
  output logic                                 last,
  // configuration
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [spnc_pkg::VC_W-1:0]            cfg_data
);

  localparam int VW = $clog2(MAX_VERTICES);        // vertex index
  localparam int NW = $clog2(MAX_VERTICES + 1);    // vertex counts, up to n
  localparam int CW = (NW > spnc_pkg::VC_W) ? NW : spnc_pkg::VC_W;
  localparam int EW = $clog2(MAX_EDGES + 1);       // edge counts
  localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

  // sequencer state
  spnc_pkg::state_t state;
  spnc_pkg::state_t state_next;

  logic [spnc_pkg::VC_W-1:0] vertex_count;
  logic [EW-1:0]             edge_total;
  logic [EW-1:0]             e;          // edge index within a pass
  logic [NW-1:0]             p;          // pass index
  logic [NW-1:0]             cnt;        // walk steps / result index
  logic                      detect;     // in the cycle check pass
  logic                      cycle;      // negative cycle found
  logic                      cyc_valid;  // walk ended on a valid vertex
  logic [VW-1:0]             cyc_start;
  logic [VW-1:0]             y;          // walk cursor
  logic                      y_ok;
  logic [spnc_pkg::VFIELD_W-1:0] start_q;

  // edge memory
  spnc_pkg::edge_t edge_mem [MAX_EDGES];
  spnc_pkg::edge_t edge_rd;
  logic            edge_we;
  logic            edge_re;
  logic [AW-1:0]   edge_ra;

  // vertex unit interface
  spnc_pkg::vs_ctrl_t ctrl;
  logic [VW-1:0]      addr_a;
  logic [VW-1:0]      addr_b;
  logic               relax;
  logic signed [spnc_pkg::DIST_W-1:0] rd_dist;
  logic               rd_reached;
  logic               pred_valid_at;
  logic [VW-1:0]      pred_at;

  // derived terms
  logic [CW-1:0] vc_w;
  logic [CW-1:0] n_w;
  logic [NW-1:0] n;
  logic          in_acc;
  logic          out_free;
  logic          out_load;
  logic          last_edge;
  logic          last_pass;
  logic          last_idx;
  logic          walk_done;
  logic          fin;
  logic          start_ok;
  logic          from_ok;
  logic          to_ok;
  logic [EW-1:0] e_next;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != spnc_pkg::ST_IDLE);
  assign in_acc    = in_valid & ~in_stall;
  assign out_free  = ~out_valid | ~out_stall;

  // active vertex count: 0 acts as 1, anything above the store size saturates
  always_comb begin
    vc_w = CW'(vertex_count);
    if (vc_w == '0) begin
      n_w = CW'(1);
    end else if (vc_w > CW'(MAX_VERTICES)) begin
      n_w = CW'(MAX_VERTICES);
    end else begin
      n_w = vc_w;
    end
    n = NW'(n_w);
  end

  assign start_ok  = CW'(start_q) < n_w;
  assign from_ok   = CW'(edge_rd.src) < n_w;
  assign to_ok     = CW'(edge_rd.dst) < n_w;
  assign last_edge = (e + EW'(1)) == edge_total;
  assign last_pass = (p + NW'(1)) == n;
  assign last_idx  = (cnt + NW'(1)) == n;
  assign walk_done = (cnt == n) | ~y_ok;
  assign fin       = ~pred_valid_at | (pred_at == cyc_start) | last_idx;
  assign e_next    = last_edge ? '0 : e + EW'(1);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      spnc_pkg::ST_IDLE: begin
        if (in_acc && action == spnc_pkg::ACT_RUN) begin
          state_next = spnc_pkg::ST_INIT;
        end
      end
      spnc_pkg::ST_INIT: begin
        state_next = (edge_total == '0) ? spnc_pkg::ST_DIST_RD : spnc_pkg::ST_EDGE_FETCH;
      end
      spnc_pkg::ST_EDGE_FETCH: begin
        state_next = spnc_pkg::ST_EDGE_EVAL;
      end
      spnc_pkg::ST_EDGE_EVAL: begin
        if (detect && relax) begin
          state_next = spnc_pkg::ST_WALK;
        end else if (last_edge && detect) begin
          state_next = spnc_pkg::ST_DIST_RD;
        end else begin
          state_next = spnc_pkg::ST_EDGE_FETCH;
        end
      end
      spnc_pkg::ST_WALK: begin
        if (walk_done) begin
          state_next = spnc_pkg::ST_DIST_RD;
        end
      end
      spnc_pkg::ST_DIST_RD: begin
        state_next = spnc_pkg::ST_DIST_EMIT;
      end
      spnc_pkg::ST_DIST_EMIT: begin
        if (out_free) begin
          if (!last_idx) begin
            state_next = spnc_pkg::ST_DIST_RD;
          end else if (cycle && cyc_valid) begin
            state_next = spnc_pkg::ST_CYC_RD;
          end else begin
            state_next = spnc_pkg::ST_IDLE;
          end
        end
      end
      spnc_pkg::ST_CYC_RD: begin
        state_next = spnc_pkg::ST_CYC_EMIT;
      end
      spnc_pkg::ST_CYC_EMIT: begin
        if (out_free) begin
          state_next = fin ? spnc_pkg::ST_IDLE : spnc_pkg::ST_CYC_RD;
        end
      end
      default: begin
        state_next = spnc_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    ctrl     = '0;
    addr_a   = '0;
    addr_b   = '0;
    edge_re  = 1'b0;
    edge_ra  = '0;
    edge_we  = 1'b0;
    out_load = 1'b0;
    case (state)
      spnc_pkg::ST_IDLE: begin
        edge_we = in_acc && action == spnc_pkg::ACT_ADD && edge_total < EW'(MAX_EDGES);
      end
      spnc_pkg::ST_INIT: begin
        ctrl.clear = 1'b1;
        ctrl.seed  = start_ok;
        addr_a     = VW'(start_q);
        edge_re    = 1'b1;
      end
      spnc_pkg::ST_EDGE_FETCH: begin
        ctrl.rd      = 1'b1;
        ctrl.edge_ok = from_ok & to_ok;
        addr_a       = VW'(edge_rd.src);
        addr_b       = VW'(edge_rd.dst);
        edge_re      = 1'b1;            // prefetch the next edge
        edge_ra      = AW'(e_next);
      end
      spnc_pkg::ST_EDGE_EVAL: begin
        ctrl.eval = 1'b1;
      end
      spnc_pkg::ST_DIST_RD: begin
        ctrl.rd = 1'b1;
        addr_a  = VW'(cnt);
      end
      spnc_pkg::ST_CYC_RD: begin
        ctrl.rd = 1'b1;
        addr_a  = y;
      end
      spnc_pkg::ST_DIST_EMIT, spnc_pkg::ST_CYC_EMIT: begin
        out_load = out_free;
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

  // edge store
  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[AW'(edge_total)] <= '{src: edge_from, dst: edge_to, weight: edge_weight};
    end
    if (edge_re) begin
      edge_rd <= edge_mem[edge_ra];
    end
  end

  spnc_vertex_unit #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_vertex (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .addr_a        (addr_a),
    .addr_b        (addr_b),
    .weight        (edge_rd.weight),
    .pred_idx      (y),
    .relax         (relax),
    .rd_dist       (rd_dist),
    .rd_reached    (rd_reached),
    .pred_valid_at (pred_valid_at),
    .pred_at       (pred_at)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= spnc_pkg::ST_IDLE;
      vertex_count <= spnc_pkg::VC_RESET;
      edge_total   <= '0;
      e            <= '0;
      p            <= '0;
      cnt          <= '0;
      detect       <= 1'b0;
      cycle        <= 1'b0;
      cyc_valid    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        vertex_count <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        spnc_pkg::ST_IDLE: begin
          if (in_acc && action == spnc_pkg::ACT_CLEAR) begin
            edge_total <= '0;
          end
          if (edge_we) begin
            edge_total <= edge_total + EW'(1);
          end
        end
        spnc_pkg::ST_INIT: begin
          e         <= '0;
          p         <= '0;
          cnt       <= '0;
          detect    <= 1'b0;
          cycle     <= 1'b0;
          cyc_valid <= 1'b0;
        end
        spnc_pkg::ST_EDGE_EVAL: begin
          if (detect && relax) begin
            cycle <= 1'b1;
            cnt   <= '0;
          end else if (last_edge) begin
            e <= '0;
            if (detect) begin
              cnt <= '0;
            end else if (last_pass) begin
              detect <= 1'b1;
            end else begin
              p <= p + NW'(1);
            end
          end else begin
            e <= e + EW'(1);
          end
        end
        spnc_pkg::ST_WALK: begin
          if (walk_done) begin
            cyc_valid <= y_ok;
            cnt       <= '0;
          end else begin
            cnt <= cnt + NW'(1);
          end
        end
        spnc_pkg::ST_DIST_EMIT: begin
          if (out_free) begin
            cnt <= last_idx ? '0 : cnt + NW'(1);
          end
        end
        spnc_pkg::ST_CYC_EMIT: begin
          if (out_free) begin
            cnt <= cnt + NW'(1);
          end
        end
        default: begin
          cnt <= cnt;
        end
      endcase
    end
  end

  // walk cursor and run operands
  always_ff @(posedge clk) begin
    case (state)
      spnc_pkg::ST_IDLE: begin
        if (in_acc) begin
          start_q <= start_vertex;
        end
      end
      spnc_pkg::ST_EDGE_FETCH: begin
        y    <= VW'(edge_rd.dst);   // walk begins at this edge if it trips the check
        y_ok <= 1'b1;
      end
      spnc_pkg::ST_WALK: begin
        if (walk_done) begin
          cyc_start <= y;
        end else begin
          y    <= pred_at;
          y_ok <= pred_valid_at;
        end
      end
      spnc_pkg::ST_DIST_EMIT: begin
        if (out_free && last_idx) begin
          y <= cyc_start;
        end
      end
      spnc_pkg::ST_CYC_EMIT: begin
        if (out_free) begin
          y <= pred_at;
        end
      end
      default: begin
        y <= y;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == spnc_pkg::ST_DIST_EMIT) begin
        kind           <= spnc_pkg::KIND_DIST;
        vertex         <= spnc_pkg::VFIELD_W'(cnt);
        distance       <= rd_reached ? rd_dist : '0;
        reachable      <= rd_reached;
        negative_cycle <= cycle;
        last           <= last_idx & ~(cycle & cyc_valid);
      end else begin
        kind           <= spnc_pkg::KIND_CYCLE;
        vertex         <= spnc_pkg::VFIELD_W'(y);
        distance       <= rd_dist;
        reachable      <= 1'b1;
        negative_cycle <= 1'b1;
        last           <= fin;
      end
    end
  end

`ifndef SYNTHESIS
  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == spnc_pkg::ST_DIST_EMIT ||
                          $past(state) == spnc_pkg::ST_CYC_EMIT))
    else $error("result beat raised outside an emit state");

  a_total_cap: assert property (@(posedge clk) disable iff (rst)
    edge_total <= EW'(MAX_EDGES))
    else $error("edge count beyond table capacity");

  a_fetch_range: assert property (@(posedge clk) disable iff (rst)
    state == spnc_pkg::ST_EDGE_FETCH |-> e < edge_total)
    else $error("edge fetch past stored edges");

  a_cycle_gate: assert property (@(posedge clk) disable iff (rst)
    state == spnc_pkg::ST_CYC_RD |-> (cycle && cyc_valid))
    else $error("cycle emit without a valid cycle");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (state == spnc_pkg::ST_DIST_RD || state == spnc_pkg::ST_CYC_RD) |-> cnt < n)
    else $error("result index beyond active vertex count");
`endif

endmodule

// ----- tb/tb_shortest_path_negative_cycle_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_shortest_path_negative_cycle_core - self-checking bench for the core
// Loads edge tables, launches searches and predicts every result beat with a
// local shortest path model; beats are checked in order under random source
// idling, sink stalls and a long sink hold-off.
// ----------------------------------------------------------------------------
module tb_shortest_path_negative_cycle_core;

  localparam int MAX_V = spnc_pkg::DEF_MAX_VERTICES;
  localparam int MAX_E = spnc_pkg::DEF_MAX_EDGES;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam longint DIST_HI = 64'sd16777215;
  localparam longint DIST_LO = -64'sd16777216;
  localparam int SETTLE_CYCLES = 8;
  localparam int END_CYCLES = 64;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic                               kind;
    logic [spnc_pkg::VFIELD_W-1:0]      vertex;
    logic signed [spnc_pkg::DIST_W-1:0] distance;
    logic                               reachable;
    logic                               negative_cycle;
    logic                               last;
  } path_result_t;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 in_valid = 1'b0;
  logic                                 in_stall;
  logic [1:0]                           action = spnc_pkg::ACT_CLEAR;
  logic [spnc_pkg::VFIELD_W-1:0]        edge_from = '0;
  logic [spnc_pkg::VFIELD_W-1:0]        edge_to = '0;
  logic signed [spnc_pkg::WEIGHT_W-1:0] edge_weight = '0;
  logic [spnc_pkg::VFIELD_W-1:0]        start_vertex = '0;
  logic                                 out_valid;
  logic                                 out_stall = 1'b0;
  logic                                 kind;
  logic [spnc_pkg::VFIELD_W-1:0]        vertex;
  logic signed [spnc_pkg::DIST_W-1:0]   distance;
  logic                                 reachable;
  logic                                 negative_cycle;
  logic                                 last;
  logic                                 cfg_valid = 1'b0;
  logic                                 cfg_ready;
  logic [spnc_pkg::VC_W-1:0]            cfg_data = '0;

  shortest_path_negative_cycle_core dut (
    .clk, .rst,
    .in_valid, .in_stall, .action, .edge_from, .edge_to, .edge_weight, .start_vertex,
    .out_valid, .out_stall, .kind, .vertex, .distance, .reachable, .negative_cycle, .last,
    .cfg_valid, .cfg_ready, .cfg_data
  );

  always #6 clk = ~clk;

  // Local copy of the core state
  spnc_pkg::edge_t           edge_mem [MAX_E];
  int unsigned               edge_count = 0;
  logic [spnc_pkg::VC_W-1:0] vc_reg = spnc_pkg::VC_RESET;
  longint                    dist_now [MAX_V];
  bit                        reached_now [MAX_V];
  int                        pred_now [MAX_V];

  path_result_t path_results_due [$];

  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  logic        holding = 1'b0;
  int          hold_len = 0;
  event        hold_go;
  int unsigned items_sent = 0;
  int unsigned searches = 0;
  int unsigned cycle_searches = 0;
  int unsigned beats_checked = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  function automatic void queue_expected(input path_result_t r);
    path_results_due.insert(path_results_due.size(), r);
  endfunction

  function automatic int unsigned active_vertices(input logic [spnc_pkg::VC_W-1:0] vc);
    if (vc == 0) return 1;
    if (vc > MAX_V) return MAX_V;
    return vc;
  endfunction

  function automatic longint saturate_dist(input longint v);
    if (v > DIST_HI) return DIST_HI;
    if (v < DIST_LO) return DIST_LO;
    return v;
  endfunction

  // Compare at full precision, store saturated.
  function automatic bit relax_edge(input spnc_pkg::edge_t e, input int unsigned n);
    longint cand;
    if (e.src >= n || e.dst >= n) return 1'b0;
    if (!reached_now[e.src]) return 1'b0;
    cand = dist_now[e.src] + longint'(e.weight);
    if (reached_now[e.dst] && cand >= dist_now[e.dst]) return 1'b0;
    dist_now[e.dst] = saturate_dist(cand);
    reached_now[e.dst] = 1'b1;
    pred_now[e.dst] = int'(e.src);
    return 1'b1;
  endfunction

  function automatic void predict_search(input logic [spnc_pkg::VFIELD_W-1:0] start_v);
    int unsigned n;
    int unsigned i;
    int unsigned p;
    int unsigned e;
    bit cyc;
    bit fin;
    int walk_head;
    int y;
    int nx;
    path_result_t r;
    n = active_vertices(vc_reg);
    for (i = 0; i < MAX_V; i++) begin
      dist_now[i] = 0;
      reached_now[i] = 1'b0;
      pred_now[i] = -1;
    end
    if (start_v < n) reached_now[start_v] = 1'b1;
    for (p = 0; p < n; p++)
      for (e = 0; e < edge_count; e++)
        void'(relax_edge(edge_mem[e], n));
    // extra pass: first edge that still improves marks a cycle
    cyc = 1'b0;
    walk_head = -1;
    for (e = 0; e < edge_count && !cyc; e++) begin
      if (relax_edge(edge_mem[e], n)) begin
        cyc = 1'b1;
        y = int'(edge_mem[e].dst);
        for (i = 0; i < n && y != -1; i++) y = pred_now[y];
        walk_head = y;
      end
    end
    for (i = 0; i < n; i++) begin
      r.kind = spnc_pkg::KIND_DIST;
      r.vertex = spnc_pkg::VFIELD_W'(i);
      r.distance = reached_now[i] ? spnc_pkg::DIST_W'(dist_now[i]) : '0;
      r.reachable = reached_now[i];
      r.negative_cycle = cyc;
      r.last = (i + 1 == n) && (!cyc || walk_head == -1);
      queue_expected(r);
    end
    if (cyc && walk_head != -1) begin
      y = walk_head;
      for (i = 0; i < n; i++) begin
        nx = pred_now[y];
        fin = (nx == -1) || (nx == walk_head) || (i + 1 == n);
        r.kind = spnc_pkg::KIND_CYCLE;
        r.vertex = spnc_pkg::VFIELD_W'(y);
        r.distance = spnc_pkg::DIST_W'(dist_now[y]);
        r.reachable = 1'b1;
        r.negative_cycle = 1'b1;
        r.last = fin;
        queue_expected(r);
        if (fin) break;
        y = nx;
      end
    end
    searches++;
    if (cyc) cycle_searches++;
  endfunction

  // One beat on the action channel; called at a rising edge.
  task automatic send_action(input logic [1:0] act,
                             input logic [spnc_pkg::VFIELD_W-1:0] from_v,
                             input logic [spnc_pkg::VFIELD_W-1:0] to_v,
                             input logic [spnc_pkg::WEIGHT_W-1:0] w,
                             input logic [spnc_pkg::VFIELD_W-1:0] start_v);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    edge_from <= from_v;
    edge_to <= to_v;
    edge_weight <= w;
    start_vertex <= start_v;
    do @(posedge clk); while (in_stall);
    case (act)
      spnc_pkg::ACT_CLEAR: edge_count = 0;
      spnc_pkg::ACT_ADD: begin
        if (edge_count < MAX_E) begin
          edge_mem[edge_count] = '{src: from_v, dst: to_v, weight: w};
          edge_count++;
        end
      end
      spnc_pkg::ACT_RUN: predict_search(start_v);
      default: ;
    endcase
    if (act != ACT_UNUSED) items_sent++;
  endtask

  task automatic clear_edges();
    send_action(spnc_pkg::ACT_CLEAR, 4'($urandom), 4'($urandom), 16'($urandom),
                4'($urandom));
  endtask

  task automatic add_edge(input logic [spnc_pkg::VFIELD_W-1:0] from_v,
                          input logic [spnc_pkg::VFIELD_W-1:0] to_v,
                          input logic [spnc_pkg::WEIGHT_W-1:0] w);
    send_action(spnc_pkg::ACT_ADD, from_v, to_v, w, 4'($urandom));
  endtask

  task automatic run_search(input logic [spnc_pkg::VFIELD_W-1:0] start_v);
    send_action(spnc_pkg::ACT_RUN, 4'($urandom), 4'($urandom), 16'($urandom), start_v);
  endtask

  // Source goes quiet until every predicted beat is back, then settles.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (path_results_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_vertex_count(input logic [spnc_pkg::VC_W-1:0] vc);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= vc;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    vc_reg = vc;
  endtask

  function automatic logic [spnc_pkg::WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(9))
      0: return spnc_pkg::WEIGHT_W'(-32768);
      1: return spnc_pkg::WEIGHT_W'(32767);
      2, 3, 4, 5: return spnc_pkg::WEIGHT_W'(int'($urandom_range(60)) - 20);
      default: return spnc_pkg::WEIGHT_W'($urandom);
    endcase
  endfunction

  // Mostly in-range endpoints, now and then anything on the port.
  function automatic logic [spnc_pkg::VFIELD_W-1:0] pick_vertex(input int unsigned n);
    if ($urandom_range(7) == 0) return spnc_pkg::VFIELD_W'($urandom);
    return spnc_pkg::VFIELD_W'($urandom_range(n - 1));
  endfunction

  function automatic logic [spnc_pkg::VC_W-1:0] pick_vertex_count();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return spnc_pkg::VC_RESET;
      3: return spnc_pkg::VC_W'($urandom_range(17, 30));
      default: return spnc_pkg::VC_W'($urandom_range(1, 9));
    endcase
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_reset_defaults();
    run_search(4'd0);
    run_search(4'd15);
  endtask

  task automatic test_vertex_count_extremes();
    set_vertex_count('0);   // behaves as one vertex
    run_search(4'd0);
    set_vertex_count('1);   // clamps to the full sixteen
    run_search(4'd15);
  endtask

  task automatic test_edge_cases();
    set_vertex_count(5'd5);
    clear_edges();
    add_edge(4'd0, 4'd1, 16'sh7fff);
    add_edge(4'd1, 4'd2, 16'sh8000);
    add_edge(4'd0, 4'd2, 16'sd4);
    add_edge(4'd3, 4'd4, 16'sd1);       // leaves a vertex that is never reached
    add_edge(4'd2, 4'd9, -16'sd5);      // endpoint beyond the vertex count
    add_edge(4'd15, 4'd15, -16'sd1);
    run_search(4'd0);
    run_search(4'd7);                   // start outside: all unreachable
    send_action(ACT_UNUSED, 4'($urandom), 4'($urandom), 16'($urandom), 4'($urandom));
  endtask

  task automatic test_negative_cycle();
    set_vertex_count(5'd4);
    clear_edges();
    add_edge(4'd0, 4'd1, 16'sd5);
    add_edge(4'd1, 4'd2, -16'sd3);
    add_edge(4'd2, 4'd1, -16'sd4);
    add_edge(4'd2, 4'd3, 16'sd1);
    run_search(4'd0);
    run_search(4'd3);
    set_vertex_count(5'd1);
    clear_edges();
    add_edge(4'd0, 4'd0, -16'sd1);
    run_search(4'd0);
  endtask

  // Mostly clean load/run sequences with random graphs, some raw noise.
  task automatic test_random_graphs(input int unsigned item_goal);
    int unsigned goal_end;
    int unsigned n;
    goal_end = items_sent + item_goal;
    while (items_sent < goal_end) begin
      if ($urandom_range(3) == 0) set_vertex_count(pick_vertex_count());
      n = active_vertices(vc_reg);
      if ($urandom_range(4) != 0) begin
        clear_edges();
        repeat ($urandom_range(1, 12)) add_edge(pick_vertex(n), pick_vertex(n), pick_weight());
        repeat ($urandom_range(1, 3)) run_search(pick_vertex(n));
      end else begin
        repeat ($urandom_range(1, 6))
          send_action(2'($urandom), 4'($urandom), 4'($urandom), 16'($urandom), 4'($urandom));
      end
    end
  endtask

  // Overfill the table; heavy negative self-loops drive the start distance
  // into the lower saturation bound.
  task automatic test_table_full();
    int unsigned k;
    set_vertex_count(spnc_pkg::VC_RESET);
    clear_edges();
    for (k = 0; k < MAX_E + 2; k++) begin
      if (k % 4 != 3) add_edge(4'd0, 4'd0, 16'(-int'($urandom_range(30000, 32768))));
      else add_edge(4'($urandom), 4'($urandom), pick_weight());
    end
    run_search(4'd0);
    run_search(4'($urandom));
  endtask

  // Sink holds off while searches keep coming, so the core backs up.
  task automatic test_backpressure();
    set_vertex_count(5'd8);
    clear_edges();
    repeat (6) add_edge(pick_vertex(8), pick_vertex(8), pick_weight());
    hold_len = 400;
    -> hold_go;
    repeat (4) run_search(pick_vertex(8));
    drain_results();
  endtask

  // ---------------------------------------------------------------- sink side

  initial forever begin
    @(hold_go);
    holding <= 1'b1;
    repeat (hold_len) @(posedge clk);
    holding <= 1'b0;
  end

  always @(posedge clk) out_stall <= holding || ($urandom_range(99) < rx_idle_pct);

  function automatic void check_field(input string fname, input logic signed [63:0] want,
                                      input logic signed [63:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    path_result_t want;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (path_results_due.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result beat, expected none, got vertex %0d", $time, vertex);
      end else begin
        want = path_results_due.pop_front();
        beats_checked++;
        check_field("kind", want.kind, kind);
        check_field("vertex", want.vertex, vertex);
        check_field("distance", want.distance, distance);
        check_field("reachable", want.reachable, reachable);
        check_field("negative_cycle", want.negative_cycle, negative_cycle);
        check_field("last", want.last, last);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d beats still due", $time, path_results_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle_pct = 11;
    rx_idle_pct = 53;
    test_reset_defaults();
    test_vertex_count_extremes();
    test_edge_cases();
    test_negative_cycle();
    test_random_graphs(70);

    tx_idle_pct = 53;
    rx_idle_pct = 11;
    test_random_graphs(70);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_graphs(70);
    test_table_full();
    test_backpressure();

    drain_results();
    repeat (END_CYCLES) @(posedge clk);
    $display("Covered %0d actions and %0d searches (%0d hit a negative cycle),",
             items_sent, searches, cycle_searches);
    $display("%0d result beats compared under idle, stall and hold-off traffic.",
             beats_checked);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
